>>> rtl/ntg_pkg.sv
// Shared types and constants for the note tone generator.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package ntg_pkg;

    // Operation codes of an input item
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_NOTE = 1'b1;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMPO_SHIFT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OCTAVE_SHIFT = 2'd1;

    // Note length: 80000 ticks for length code 0
    localparam int LEN_W = 17;
    localparam logic [LEN_W-1:0] BASE_LENGTH = 17'd80000;

    // Half period ROM: H = floor((5e13 << k) / F[r]) for k = 0..ROM_SHIFTS-1
    localparam int HALF_W           = 16;
    localparam int SEMIS_PER_OCTAVE = 12;
    localparam int ROM_SHIFTS       = 10;
    localparam logic [HALF_W-1:0] HALF_MAX = 16'hFFFF;
    localparam logic [63:0] HALF_NUMERATOR = 64'd50000000000000;
    localparam logic [63:0] FREQ_SCALED [SEMIS_PER_OCTAVE] = '{
        64'd220000000000, 64'd233081880759, 64'd246941650628, 64'd261625565301,
        64'd277182630977, 64'd293664767917, 64'd311126983722, 64'd329627556913,
        64'd349228231433, 64'd369994422712, 64'd391995435982, 64'd415304697580
    };

    typedef struct packed {
        logic       operation;
        logic [3:0] note_index;
        logic [3:0] octave_number;
        logic [2:0] length_code;
        logic       rest_flag;
    } ntg_in_t;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic note_done;
    } ntg_out_t;

    typedef struct packed {
        logic [2:0]        tempo_shift;
        logic signed [3:0] octave_shift;
    } ntg_cfg_t;

endpackage

`default_nettype wire

>>> rtl/ntg_half_rom.sv
// Semitone to half-period lookup, built at elaboration from the pitch constants.
// Depends on ntg_pkg.
`default_nettype none

module ntg_half_rom (
    input  wire logic [3:0]        note_index,
    input  wire logic [3:0]        octave_number,
    input  wire logic signed [3:0] octave_shift,
    output logic [ntg_pkg::HALF_W-1:0] half_period
);
    import ntg_pkg::*;

    // octave offset bucket qq: the semitone lies in octave qq - Q_ZERO
    localparam logic [5:0] Q_ZERO = 6'd12;
    localparam logic [5:0] Q_SAT  = 6'(12 - ROM_SHIFTS + 1);

    logic [HALF_W-1:0] tbl [ROM_SHIFTS][SEMIS_PER_OCTAVE];

    for (genvar k = 0; k < ROM_SHIFTS; k++) begin : g_shift
        for (genvar r = 0; r < SEMIS_PER_OCTAVE; r++) begin : g_semi
            localparam logic [63:0] RAW = (HALF_NUMERATOR << k) / FREQ_SCALED[r];
            assign tbl[k][r] = (RAW > {48'd0, HALF_MAX}) ? HALF_MAX : RAW[HALF_W-1:0];
        end
    end

    logic [5:0]        oct_sum;
    logic              wrap;
    logic [3:0]        semi_r;
    logic [5:0]        qq;
    logic [5:0]        rom_k;
    logic [5:0]        down_sh;
    logic [HALF_W-1:0] shifted;

    always_comb begin
        oct_sum = {2'b00, octave_number} + {{2{octave_shift[3]}}, octave_shift} + 6'd8;
        wrap    = (note_index >= 4'd12);
        semi_r  = wrap ? (note_index - 4'd12) : note_index;
        qq      = oct_sum + {5'd0, wrap};
        rom_k   = Q_ZERO - qq;
        down_sh = qq - Q_ZERO;
        shifted = tbl[0][semi_r] >> down_sh[4:0];
        if (qq < Q_SAT) begin
            half_period = HALF_MAX;
        end else if (qq <= Q_ZERO) begin
            half_period = tbl[rom_k[3:0]][semi_r];
        end else if (shifted == '0) begin
            half_period = HALF_W'(1);
        end else begin
            half_period = shifted;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ntg_voice.sv
// Note state: length budget, phase counter and pin level, updated once per item.
// Depends on ntg_pkg and ntg_half_rom.
`default_nettype none

module ntg_voice (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire ntg_pkg::ntg_in_t  item,
    input  wire ntg_pkg::ntg_cfg_t cfg,
    output ntg_pkg::ntg_out_t      result
);
    import ntg_pkg::*;

    logic              active_reg,  active_next;
    logic              resting_reg, resting_next;
    logic              level_reg,   level_next;
    logic [HALF_W-1:0] half_reg,    half_next;
    logic [HALF_W-1:0] phase_reg,   phase_next;
    logic [LEN_W-1:0]  rem_reg,     rem_next;
    logic              done;

    logic [HALF_W-1:0] rom_half;
    logic [3:0]        len_sh;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  new_period;
    logic [LEN_W-1:0]  cur_period;
    logic [HALF_W-1:0] phase_inc;
    logic [LEN_W-1:0]  rem_after;

    ntg_half_rom u_rom (
        .note_index    (item.note_index),
        .octave_number (item.octave_number),
        .octave_shift  (cfg.octave_shift),
        .half_period   (rom_half)
    );

    always_comb begin
        len_sh     = {1'b0, item.length_code} + {1'b0, cfg.tempo_shift};
        len        = BASE_LENGTH >> len_sh;
        new_period = {rom_half, 1'b0};
        cur_period = {half_reg, 1'b0};
        phase_inc  = phase_reg + HALF_W'(1);
        rem_after  = rem_reg - cur_period;

        active_next  = active_reg;
        resting_next = resting_reg;
        level_next   = level_reg;
        half_next    = half_reg;
        phase_next   = phase_reg;
        rem_next     = rem_reg;
        done         = 1'b0;

        if (item.operation == OP_NOTE) begin
            resting_next = item.rest_flag;
            half_next    = rom_half;
            phase_next   = '0;
            rem_next     = len;
            if (item.rest_flag) begin
                active_next = 1'b1;
                level_next  = 1'b0;
            end else begin
                // at least one full period has to fit, otherwise stay silent
                active_next = (len >= new_period);
                level_next  = (len >= new_period);
            end
        end else if (active_reg) begin
            if (resting_reg) begin
                rem_next = rem_reg - LEN_W'(1);
                if (rem_reg == LEN_W'(1)) begin
                    active_next = 1'b0;
                    done        = 1'b1;
                end
            end else if (phase_inc == half_reg) begin
                phase_next = '0;
                level_next = !level_reg;
                // low to high ends a period; stop if the next one will not fit
                if (!level_reg) begin
                    rem_next = rem_after;
                    if (rem_after < cur_period) begin
                        active_next = 1'b0;
                        level_next  = 1'b0;
                        done        = 1'b1;
                    end
                end
            end else begin
                phase_next = phase_inc;
            end
        end

        result.pin_level = level_next;
        result.busy_res  = active_next;
        result.note_done = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            resting_reg <= 1'b0;
            level_reg   <= 1'b0;
        end else if (step) begin
            active_reg  <= active_next;
            resting_reg <= resting_next;
            level_reg   <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            half_reg  <= half_next;
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/note_tone_generator.sv
// Top level: input register, configuration registers, voice and result register.
// Depends on ntg_pkg and ntg_voice.
`default_nettype none

// Square wave note generator. Each input transfer is either a one microsecond
// tick or a note command; each produces exactly one result transfer carrying
// the pin level, busy flag and end-of-note flag after that item. One item is
// taken every clock cycle when the result side keeps up; an item is held in
// the input register and its result in the result register.
// The cycle is bounded by the command path: semitone arithmetic, the
// half-period ROM lookup and the length-versus-period compare. tempo_shift
// (index 0) and octave_shift (index 1) are written through the cfg port, others
// ignored; the user must write only while no note is in flight (unenforced).

module note_tone_generator (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire ntg_pkg::ntg_in_t               s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output ntg_pkg::ntg_out_t                   m_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ntg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ntg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ntg_pkg::*;

    logic      in_vld_reg;
    ntg_in_t   in_reg;
    logic      out_vld_reg;
    ntg_out_t  out_reg;
    ntg_cfg_t  cfg_reg;
    ntg_out_t  voice_res;
    logic      advance;
    logic      step;

    assign advance   = !out_vld_reg || m_ready;
    assign step      = in_vld_reg && advance;
    assign s_ready   = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_vld_reg;
    assign m_data    = out_reg;

    ntg_voice u_voice (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_reg),
        .cfg     (cfg_reg),
        .result  (voice_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (step) begin
                in_vld_reg <= 1'b0;
            end
            if (step) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (step) begin
            out_reg <= voice_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TEMPO_SHIFT:  cfg_reg.tempo_shift  <= cfg_data[2:0];
                REG_OCTAVE_SHIFT: cfg_reg.octave_shift <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire
